[rtl/blbd_pkg.sv]
package blbd_pkg;

  // register and field widths
  localparam int LSIDE_W = 13;
  localparam int OSIDE_W = 9;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 25;
  localparam int AVG_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int AREA_W  = 2 * LSIDE_W;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register index codes (paddr[2])
  localparam logic REG_LSIDE = 1'b0;
  localparam logic REG_OSIDE = 1'b1;

  localparam logic [LSIDE_W-1:0] LSIDE_RESET = LSIDE_W'(256);
  localparam logic [OSIDE_W-1:0] OSIDE_RESET = OSIDE_W'(64);

  localparam int MAX_OUT_SIDE_DEF     = 256;
  localparam int MAX_LATTICE_SIDE_DEF = 4096;

  // serial divider: quotient width and iteration counter width
  localparam int DIV_D_W    = AVG_W;
  localparam int DIV_ITER_W = $clog2(DIV_D_W + 1);

  typedef struct packed {
    logic                  start;
    logic [AREA_W-1:0]     rem_init;
    logic [DIV_D_W-1:0]    bits_init;
    logic [AREA_W-1:0]     divisor;
    logic [DIV_ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_D_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/blbd_div.sv]
module blbd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blbd_pkg::div_req_t req_i,
  output blbd_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [blbd_pkg::DIV_ITER_W-1:0] cnt_q, cnt_d;
  logic [blbd_pkg::AREA_W-1:0]     rem_q, rem_d;
  logic [blbd_pkg::AREA_W-1:0]     dvs_q, dvs_d;
  logic [blbd_pkg::DIV_D_W-1:0]    bits_q, bits_d;
  logic [blbd_pkg::DIV_D_W-1:0]    quot_q, quot_d;
  logic [blbd_pkg::AREA_W:0]       rem_sh;
  logic                            ge;

  // one restoring step per cycle; the partial remainder stays below the divisor if it starts below it
  always_comb begin
    rem_sh = {rem_q, bits_q[blbd_pkg::DIV_D_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    bits_d = bits_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = req_i.rem_init;
      dvs_d  = req_i.divisor;
      bits_d = req_i.bits_init;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? blbd_pkg::AREA_W'(rem_sh - {1'b0, dvs_q})
                  : blbd_pkg::AREA_W'(rem_sh);
      bits_d = {bits_q[blbd_pkg::DIV_D_W-2:0], 1'b0};
      quot_d = {quot_q[blbd_pkg::DIV_D_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == blbd_pkg::DIV_ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[rtl/bit_lattice_box_downsampler_core.sv]
// Box-filter downsampler for a square lattice of one-bit cells. Cells stream in raster order,
// one beat per cell, and each k by k block (k = lattice_side / out_side) leaves one beat with
// its position, set count and Q1.16 average. A cell is taken every cycle; after the cell that
// closes a block the input stalls while the sum is updated, the shared serial divider forms the
// average one quotient bit per cycle, and the result is handed over. A finished pixel waits
// in the output register without holding up input; a second finished pixel stalls the input
// until the first one leaves. Running column sums live in a single-port-write, registered-read
// memory of MAX_OUT_SIDE entries. After reset and after every register write the block
// recomputes k with the same divider and clears the sum memory, one entry per cycle, with the
// input stalled meanwhile. Register writes restart the lattice at row 0, column 0.
module bit_lattice_box_downsampler_core #(
  parameter int MAX_OUT_SIDE     = blbd_pkg::MAX_OUT_SIDE_DEF,
  parameter int MAX_LATTICE_SIDE = blbd_pkg::MAX_LATTICE_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blbd_pkg::ADDR_W-1:0]   paddr,
  input  logic [blbd_pkg::DATA_W-1:0]   pwdata,
  output logic [blbd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // cell input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cell_value_i,
  // pixel output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [blbd_pkg::PIX_W-1:0]    pixel_row_o,
  output logic [blbd_pkg::PIX_W-1:0]    pixel_col_o,
  output logic [blbd_pkg::SUM_W-1:0]    set_count_o,
  output logic [blbd_pkg::AVG_W-1:0]    average_q16_o,
  output logic                          last_pixel_o
);

  localparam int POS_W = (MAX_LATTICE_SIDE > 1) ? $clog2(MAX_LATTICE_SIDE) : 1;
  localparam int OC_W  = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
  localparam int LS_MAXV = (1 << blbd_pkg::LSIDE_W) - 1;
  localparam int OS_MAXV = (1 << blbd_pkg::OSIDE_W) - 1;
  localparam int NCAP  = (MAX_LATTICE_SIDE < LS_MAXV) ? MAX_LATTICE_SIDE : LS_MAXV;
  localparam int MCAP  = (MAX_OUT_SIDE < OS_MAXV) ? MAX_OUT_SIDE : OS_MAXV;
  localparam int CW    = ((POS_W > blbd_pkg::LSIDE_W) ? POS_W : blbd_pkg::LSIDE_W) + 1;
  localparam int PADW  = blbd_pkg::DIV_D_W - blbd_pkg::LSIDE_W;

  localparam logic [1:0] ST_START = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_AREA  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  // registers
  logic [blbd_pkg::LSIDE_W-1:0] lside_q;
  logic [blbd_pkg::OSIDE_W-1:0] oside_q;
  logic                         cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == blbd_pkg::REG_OSIDE) ? blbd_pkg::DATA_W'(oside_q)
                                                    : blbd_pkg::DATA_W'(lside_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lside_q <= blbd_pkg::LSIDE_RESET;
      oside_q <= blbd_pkg::OSIDE_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == blbd_pkg::REG_OSIDE) begin
        oside_q <= pwdata[blbd_pkg::OSIDE_W-1:0];
      end else begin
        lside_q <= pwdata[blbd_pkg::LSIDE_W-1:0];
      end
    end
  end

  logic [blbd_pkg::LSIDE_W-1:0] n_eff;
  logic [blbd_pkg::OSIDE_W-1:0] m_eff;

  always_comb begin
    if (lside_q == '0) begin
      n_eff = blbd_pkg::LSIDE_W'(1);
    end else if (lside_q > blbd_pkg::LSIDE_W'(NCAP)) begin
      n_eff = blbd_pkg::LSIDE_W'(NCAP);
    end else begin
      n_eff = lside_q;
    end
    m_eff = (oside_q > blbd_pkg::OSIDE_W'(MCAP)) ? blbd_pkg::OSIDE_W'(MCAP) : oside_q;
  end

  // init sequencer, divider
  logic [1:0]                   st_q;
  logic [OC_W-1:0]              clr_cnt_q;
  logic                         clr_done_q;
  logic                         k_rdy_q;
  logic [blbd_pkg::LSIDE_W-1:0] k_q;
  logic [blbd_pkg::AREA_W-1:0]  area_q;
  blbd_pkg::div_req_t           div_req;
  blbd_pkg::div_rsp_t           div_rsp;
  logic                         done_run;

  blbd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign done_run = div_rsp.done && (st_q == ST_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_START;
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
      k_rdy_q    <= 1'b0;
      k_q        <= '0;
      area_q     <= '0;
    end else if (cfg_we) begin
      st_q <= ST_START;
    end else begin
      unique case (st_q)
        ST_START: begin
          st_q       <= ST_INIT;
          clr_cnt_q  <= '0;
          clr_done_q <= 1'b0;
          k_rdy_q    <= 1'b0;
        end
        ST_INIT: begin
          if (!clr_done_q) begin
            if (clr_cnt_q == OC_W'(MAX_OUT_SIDE - 1)) begin
              clr_done_q <= 1'b1;
            end else begin
              clr_cnt_q <= clr_cnt_q + 1'b1;
            end
          end
          if (div_rsp.done) begin
            k_q     <= (m_eff == '0) ? '0 : div_rsp.quot[blbd_pkg::LSIDE_W-1:0];
            k_rdy_q <= 1'b1;
          end
          if (clr_done_q && k_rdy_q) begin
            st_q <= ST_AREA;
          end
        end
        ST_AREA: begin
          area_q <= k_q * k_q;
          st_q   <= ST_RUN;
        end
        ST_RUN: begin
          st_q <= ST_RUN;
        end
        default: begin
          st_q <= ST_START;
        end
      endcase
    end
  end

  // position counters
  logic [POS_W-1:0]             c_q, cb_q, r_q, rb_q;
  logic [blbd_pkg::OSIDE_W-1:0] oc_q, or_q;
  logic [POS_W-1:0]             km1;
  logic                         in_acc, col_wrap, row_wrap, col_end, row_end;
  logic                         in_range, emit, at_last;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign km1        = POS_W'(k_q - 1'b1);
  assign col_wrap   = (CW'(c_q) + 1'b1) >= CW'(n_eff);
  assign row_wrap   = (CW'(r_q) + 1'b1) >= CW'(n_eff);
  assign col_end    = cb_q == km1;
  assign row_end    = rb_q == km1;
  assign in_range   = (k_q != '0) && (oc_q < m_eff) && (or_q < m_eff);
  assign emit       = in_range && col_end && row_end;
  assign at_last    = (or_q == m_eff - 1'b1) && (oc_q == m_eff - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q  <= '0;
      cb_q <= '0;
      oc_q <= '0;
      r_q  <= '0;
      rb_q <= '0;
      or_q <= '0;
    end else if (cfg_we) begin
      c_q  <= '0;
      cb_q <= '0;
      oc_q <= '0;
      r_q  <= '0;
      rb_q <= '0;
      or_q <= '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        c_q  <= '0;
        cb_q <= '0;
        oc_q <= '0;
        if (row_wrap) begin
          r_q  <= '0;
          rb_q <= '0;
          or_q <= '0;
        end else begin
          r_q  <= r_q + 1'b1;
          rb_q <= row_end ? '0 : rb_q + 1'b1;
          if (row_end && (or_q != m_eff)) begin
            or_q <= or_q + 1'b1;
          end
        end
      end else begin
        c_q  <= c_q + 1'b1;
        cb_q <= col_end ? '0 : cb_q + 1'b1;
        // column index parks at out_side once past the last full block
        if (col_end && (oc_q != m_eff)) begin
          oc_q <= oc_q + 1'b1;
        end
      end
    end
  end

  // column sum memory
  logic [blbd_pkg::SUM_W-1:0] sums_mem [MAX_OUT_SIDE];
  logic [blbd_pkg::SUM_W-1:0] mem_rdata_q;
  logic                       mem_we, mem_re;
  logic [OC_W-1:0]            mem_waddr, mem_raddr;
  logic [blbd_pkg::SUM_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sums_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= sums_mem[mem_raddr];
    end
  end

  assign mem_re    = in_acc && in_range;
  assign mem_raddr = OC_W'(oc_q);

  // read stage
  logic                         s1_valid_q, s1_emit_q, s1_cell_q, s1_last_q;
  logic [OC_W-1:0]              s1_addr_q;
  logic [blbd_pkg::OSIDE_W-1:0] s1_row_q, s1_col_q;
  logic                         fwd_hit_q;
  logic [blbd_pkg::SUM_W-1:0]   fwd_data_q;
  logic [blbd_pkg::SUM_W-1:0]   operand, sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_emit_q  <= emit;
    s1_cell_q  <= cell_value_i;
    s1_last_q  <= at_last;
    s1_addr_q  <= mem_raddr;
    s1_row_q   <= or_q;
    s1_col_q   <= oc_q;
    // the write of the previous beat to the same entry is not yet visible in the read data
    fwd_hit_q  <= mem_we && (mem_waddr == mem_raddr);
    fwd_data_q <= mem_wdata;
  end

  assign operand = fwd_hit_q ? fwd_data_q : mem_rdata_q;
  assign sum     = operand + blbd_pkg::SUM_W'(s1_cell_q);

  always_comb begin
    if (st_q == ST_INIT && !clr_done_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_valid_q;
      mem_waddr = s1_addr_q;
      mem_wdata = s1_emit_q ? '0 : sum;
    end
  end

  // divider requests: k at init, average per closed block
  always_comb begin
    div_req = '0;
    if (st_q == ST_START && !cfg_we) begin
      div_req.start     = 1'b1;
      div_req.rem_init  = '0;
      div_req.bits_init = {n_eff, {PADW{1'b0}}};
      div_req.divisor   = blbd_pkg::AREA_W'(m_eff);
      div_req.iters     = blbd_pkg::DIV_ITER_W'(blbd_pkg::LSIDE_W);
    end else if (s1_valid_q && s1_emit_q) begin
      // count << 16: top bits preload the remainder, quotient fits 17 bits
      div_req.start     = 1'b1;
      div_req.rem_init  = blbd_pkg::AREA_W'(sum >> 1);
      div_req.bits_init = {sum[0], {blbd_pkg::FRAC_W{1'b0}}};
      div_req.divisor   = area_q;
      div_req.iters     = blbd_pkg::DIV_ITER_W'(blbd_pkg::DIV_D_W);
    end
  end

  // pixel held while its average is formed
  logic [blbd_pkg::OSIDE_W-1:0] h_row_q, h_col_q;
  logic [blbd_pkg::SUM_W-1:0]   h_cnt_q;
  logic                         h_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_emit_q) begin
      h_row_q  <= s1_row_q;
      h_col_q  <= s1_col_q;
      h_cnt_q  <= sum;
      h_last_q <= s1_last_q;
    end
  end

  // output register
  logic pend_q;
  logic out_valid_q;
  logic out_free, out_load;

  assign in_stall_o = (st_q != ST_RUN) || div_rsp.busy || div_rsp.done || pend_q ||
                      (s1_valid_q && s1_emit_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (done_run || pend_q) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (done_run && !out_free) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_row_o   <= h_row_q[blbd_pkg::PIX_W-1:0];
      pixel_col_o   <= h_col_q[blbd_pkg::PIX_W-1:0];
      set_count_o   <= h_cnt_q;
      average_q16_o <= div_rsp.quot;
      last_pixel_o  <= h_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
